FILE: hdl/sptdr_pkg.sv
// Shared types and codes for the split-path TCP destination rewriter.
package sptdr_pkg;

    localparam logic [2:0] ACT_SEND       = 3'd0;
    localparam logic [2:0] ACT_RECV       = 3'd1;
    localparam logic [2:0] ACT_APPEND_SND = 3'd2;
    localparam logic [2:0] ACT_APPEND_RCV = 3'd3;
    localparam logic [2:0] ACT_FLUSH_SND  = 3'd4;
    localparam logic [2:0] ACT_FLUSH_RCV  = 3'd5;

    localparam int unsigned PAIR_W = 48;
    localparam logic [15:0] TCP_PROTO = 16'd6;

    // Operand set for one checksum/pseudo-sum job.
    typedef struct packed {
        logic [31:0] src;
        logic [31:0] old_dst;
        logic [31:0] new_dst;
        logic [15:0] seg_len;
        logic [15:0] old_ck;
    } t_ck_req;

    typedef struct packed {
        logic [15:0] ip_ck;
        logic [15:0] pseudo;
    } t_ck_res;

endpackage

FILE: hdl/split_path_tcp_dest_rewriter_unit.sv
// Top level: rule tables, first-match search sequencer and result register.
//
// One beat is accepted at a time. A packet beat scans the selected table one
// rule per cycle behind the registered RAM read, stopping at the first hit,
// so the scan checks at most count rules, up to RULES. A rewrite then runs the
// shared ones-complement adder over eleven terms, driven by the start pulse
// and ending with the done flag. Appends and flushes skip the scan and go
// straight to the output state. The rule scan and the serial adder set the
// rate. The output register holds the result until taken; no new beat is
// accepted before it leaves.
module split_path_tcp_dest_rewriter_unit import sptdr_pkg::*; #(
    parameter int RULES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_action,
    input  logic [31:0] i_pri_addr,
    input  logic [15:0] i_pri_port,
    input  logic [31:0] i_sec_addr,
    input  logic [15:0] i_sec_port,
    input  logic [63:0] i_pattern,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [15:0] i_dst_port,
    input  logic [15:0] i_segment_len,
    input  logic [15:0] i_old_ip_checksum,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_rewritten,
    output logic [31:0] o_new_dst_addr,
    output logic [15:0] o_new_dst_port,
    output logic [15:0] o_new_ip_checksum,
    output logic [15:0] o_pseudo_sum,
    output logic [0:0]  o_status
);

    localparam int IW = (RULES > 1) ? $clog2(RULES) : 1;
    localparam int CW = $clog2(RULES + 1);
    localparam int RD = (RULES > 1) ? RULES : 2;
    localparam logic [CW-1:0] FULL = CW'(RULES);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_CK   = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [CW-1:0]     r_scnt, r_rcnt;
    logic [CW-1:0]     r_idx;
    logic [RULES-1:0]  r_pos_ok;          // position valid (else reads zero)
    logic [5:0]        r_pos [RULES];
    logic [2:0]        r_act;
    logic [47:0]       r_pkt;
    logic [31:0]       r_src;
    logic [15:0]       r_seg, r_ock;
    logic              r_ovalid;
    logic              r_rew;
    logic [31:0]       r_ndst;
    logic [15:0]       r_nport, r_nck, r_ps;
    logic              r_stat;
    logic              r_ck_start;

    // table memories
    logic              w_swe, w_rwe;
    logic [IW-1:0]     w_swa, w_rwa, w_ra;
    logic [PAIR_W-1:0] w_sp, w_ss, w_rp, w_rs;
    logic [63:0]       w_pat;

    assign w_swe = (r_state == S_IDLE) && i_valid && !o_stall
                   && (i_action == ACT_APPEND_SND) && (r_scnt < FULL);
    assign w_rwe = (r_state == S_IDLE) && i_valid && !o_stall
                   && (i_action == ACT_APPEND_RCV) && (r_rcnt < FULL);
    assign w_swa = r_scnt[IW-1:0];
    assign w_rwa = r_rcnt[IW-1:0];
    assign w_ra  = r_idx[IW-1:0];

    sptdr_ram #(.WIDTH(PAIR_W), .DEPTH(RD)) u_sp (.i_clk, .i_we(w_swe), .i_waddr(w_swa),
        .i_wdata({i_pri_addr, i_pri_port}), .i_raddr(w_ra), .o_rdata(w_sp));
    sptdr_ram #(.WIDTH(PAIR_W), .DEPTH(RD)) u_ss (.i_clk, .i_we(w_swe), .i_waddr(w_swa),
        .i_wdata({i_sec_addr, i_sec_port}), .i_raddr(w_ra), .o_rdata(w_ss));
    sptdr_ram #(.WIDTH(64), .DEPTH(RD)) u_pat (.i_clk, .i_we(w_swe), .i_waddr(w_swa),
        .i_wdata(i_pattern), .i_raddr(w_ra), .o_rdata(w_pat));
    sptdr_ram #(.WIDTH(PAIR_W), .DEPTH(RD)) u_rp (.i_clk, .i_we(w_rwe), .i_waddr(w_rwa),
        .i_wdata({i_pri_addr, i_pri_port}), .i_raddr(w_ra), .o_rdata(w_rp));
    sptdr_ram #(.WIDTH(PAIR_W), .DEPTH(RD)) u_rs (.i_clk, .i_we(w_rwe), .i_waddr(w_rwa),
        .i_wdata({i_sec_addr, i_sec_port}), .i_raddr(w_ra), .o_rdata(w_rs));

    // checksum unit
    t_ck_req w_req;
    t_ck_res w_res;
    logic    w_ck_done;

    assign w_req.src     = r_src;
    assign w_req.old_dst = r_pkt[47:16];
    assign w_req.new_dst = r_ndst;
    assign w_req.seg_len = r_seg;
    assign w_req.old_ck  = r_ock;

    sptdr_cksum u_ck (.i_clk, .i_rst_n, .i_start(r_ck_start), .i_req(w_req),
        .o_done(w_ck_done), .o_res(w_res));

    assign o_stall = (r_state != S_IDLE) || r_ovalid;

    // candidate compare on the registered read (index r_idx-1 was read)
    logic [IW-1:0] w_hidx;
    logic [CW-1:0] w_cnt;
    logic          w_hit;
    logic [5:0]    w_pos;
    logic          w_bit;

    assign w_hidx = w_ra - IW'(1);
    assign w_cnt  = (r_act == ACT_SEND) ? r_scnt : r_rcnt;
    assign w_hit  = (r_act == ACT_SEND) ? (w_sp == r_pkt) : (w_rs == r_pkt);
    assign w_pos  = r_pos_ok[w_hidx] ? r_pos[w_hidx] : 6'd0;
    assign w_bit  = w_pat[w_pos];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid && !o_stall) begin
                n_state = ((i_action == ACT_SEND) || (i_action == ACT_RECV))
                          ? S_SCAN : S_OUT;
            end
            S_SCAN: n_state = (w_cnt == '0) ? S_OUT : S_CHK;
            S_CHK: begin
                if (w_hit) begin
                    n_state = ((r_act == ACT_RECV) || w_bit) ? S_CK : S_OUT;
                end else if (r_idx == w_cnt) begin
                    n_state = S_OUT;
                end
            end
            S_CK:    if (w_ck_done) n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_scnt   <= '0;
            r_rcnt   <= '0;
            r_pos_ok <= '0;
            r_ovalid <= 1'b0;
            r_ck_start <= 1'b0;
        end else begin
            r_state <= n_state;
            // start the adder in the cycle after a hit that rewrites
            r_ck_start <= (r_state == S_CHK) && w_hit && ((r_act == ACT_RECV) || w_bit);
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_valid && !o_stall) begin
                    r_act <= i_action;
                    r_pkt <= {i_dst_addr, i_dst_port};
                    r_src <= i_src_addr;
                    r_seg <= i_segment_len;
                    r_ock <= i_old_ip_checksum;
                    r_idx <= '0;
                    r_rew <= 1'b0;
                    r_stat <= 1'b0;
                    case (i_action)
                        ACT_APPEND_SND: begin
                            if (r_scnt < FULL) begin
                                r_pos_ok[w_swa] <= 1'b1;
                                r_pos[w_swa]    <= 6'd0;
                                r_scnt          <= r_scnt + CW'(1);
                            end else begin
                                r_stat <= 1'b1;
                            end
                        end
                        ACT_APPEND_RCV: begin
                            if (r_rcnt < FULL) r_rcnt <= r_rcnt + CW'(1);
                            else r_stat <= 1'b1;
                        end
                        ACT_FLUSH_SND: r_scnt <= '0;
                        ACT_FLUSH_RCV: r_rcnt <= '0;
                        default: ;
                    endcase
                end
                S_SCAN: r_idx <= r_idx + CW'(1);
                S_CHK: begin
                    if (w_hit) begin
                        if (r_act == ACT_SEND) begin
                            r_pos_ok[w_hidx] <= 1'b1;
                            r_pos[w_hidx]    <= w_pos + 6'd1;
                            r_ndst  <= w_ss[47:16];
                            r_nport <= w_ss[15:0];
                        end else begin
                            r_ndst  <= w_rp[47:16];
                            r_nport <= w_rp[15:0];
                        end
                        if ((r_act == ACT_RECV) || w_bit) begin
                            r_rew <= 1'b1;
                        end
                    end else if (r_idx != w_cnt) begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                S_CK: if (w_ck_done) begin
                    r_nck <= w_res.ip_ck;
                    r_ps  <= w_res.pseudo;
                end
                S_OUT: r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end

    assign o_valid           = r_ovalid;
    assign o_rewritten       = r_rew;
    assign o_new_dst_addr    = r_rew ? r_ndst  : r_pkt[47:16];
    assign o_new_dst_port    = r_rew ? r_nport : r_pkt[15:0];
    assign o_new_ip_checksum = r_rew ? r_nck   : r_ock;
    assign o_pseudo_sum      = r_rew ? r_ps    : 16'd0;
    assign o_status          = r_stat;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_scnt <= FULL) && (r_rcnt <= FULL)) else $error("table count overflow");
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid) else $error("result dropped under stall");
    a_ck_only_rew: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CK) |-> r_rew) else $error("checksum run without rewrite");
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("accepting while result pending");

endmodule

FILE: hdl/sptdr_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module sptdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/sptdr_cksum.sv
// Shared 16-bit ones-complement adder sequenced over checksum and pseudo-header terms.
module sptdr_cksum import sptdr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_ck_req i_req,
    output logic    o_done,
    output t_ck_res o_res
);

    // step 0..4: checksum terms, 5..10: pseudo terms, then finish
    logic [3:0]  r_step, n_step;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [15:0] r_acc, n_acc;
    logic [15:0] r_ck, n_ck;
    t_ck_req     r_req;
    logic [15:0] w_term;
    logic [16:0] w_sum;
    logic [15:0] w_fold;

    always_comb begin
        case (r_step)
            4'd0:    w_term = ~r_req.old_ck;
            4'd1:    w_term = ~r_req.old_dst[31:16];
            4'd2:    w_term = ~r_req.old_dst[15:0];
            4'd3:    w_term = r_req.new_dst[31:16];
            4'd4:    w_term = r_req.new_dst[15:0];
            4'd5:    w_term = r_req.src[31:16];
            4'd6:    w_term = r_req.src[15:0];
            4'd7:    w_term = r_req.new_dst[31:16];
            4'd8:    w_term = r_req.new_dst[15:0];
            4'd9:    w_term = TCP_PROTO;
            4'd10:   w_term = r_req.seg_len;
            default: w_term = 16'd0;
        endcase
    end

    // end-around carry add; acc starts at 0 so folding stays exact
    assign w_sum  = {1'b0, r_acc} + {1'b0, w_term};
    assign w_fold = w_sum[15:0] + {15'd0, w_sum[16]};

    always_comb begin
        n_step = r_step;
        n_busy = r_busy;
        n_acc  = r_acc;
        n_ck   = r_ck;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = 4'd0;
            n_acc  = 16'd0;
        end else if (r_busy) begin
            n_acc  = w_fold;
            n_step = r_step + 4'd1;
            if (r_step == 4'd4) begin
                n_ck  = ~w_fold;
                n_acc = 16'd0;
            end
            if (r_step == 4'd10) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 4'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_acc <= n_acc;
        r_ck  <= n_ck;
        if (i_start) begin
            r_req <= i_req;
        end
    end

    assign o_done       = r_done;
    assign o_res.ip_ck  = r_ck;
    assign o_res.pseudo = r_acc;

    // done is one pulse after the last term
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("cksum done not a single pulse");
    a_done_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_done) |-> $past(r_busy) && $past(r_step) == 4'd10)
        else $error("cksum done without final step");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start) else $error("cksum restarted while busy");

endmodule

FILE: dv/split_path_tcp_dest_rewriter_unit_tb.sv
// Testbench for the split-path TCP destination rewriter: directed and random beats.
`timescale 1ns / 100ps

module split_path_tcp_dest_rewriter_unit_tb import sptdr_pkg::*;;

    localparam int NRULES = 16;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_action;
    logic [31:0] i_pri_addr;
    logic [15:0] i_pri_port;
    logic [31:0] i_sec_addr;
    logic [15:0] i_sec_port;
    logic [63:0] i_pattern;
    logic [31:0] i_src_addr;
    logic [31:0] i_dst_addr;
    logic [15:0] i_dst_port;
    logic [15:0] i_segment_len;
    logic [15:0] i_old_ip_checksum;
    logic        o_valid;
    logic        i_stall;
    logic        o_rewritten;
    logic [31:0] o_new_dst_addr;
    logic [15:0] o_new_dst_port;
    logic [15:0] o_new_ip_checksum;
    logic [15:0] o_pseudo_sum;
    logic [0:0]  o_status;

    typedef struct packed {
        logic        rewritten;
        logic [31:0] dst_addr;
        logic [15:0] dst_port;
        logic [15:0] ip_ck;
        logic [15:0] pseudo;
        logic        status;
    } t_rewrite_out;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] pri_addr;
        logic [15:0] pri_port;
        logic [31:0] sec_addr;
        logic [15:0] sec_port;
        logic [63:0] pattern;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] dst_port;
        logic [15:0] seg_len;
        logic [15:0] old_ck;
    } t_beat;

    // Mirror of the rule tables
    logic [47:0] snd_pri [NRULES];
    logic [47:0] snd_sec [NRULES];
    logic [63:0] snd_pat [NRULES];
    logic [5:0]  snd_pos [NRULES];
    int          snd_cnt;
    logic [47:0] rcv_pri [NRULES];
    logic [47:0] rcv_sec [NRULES];
    int          rcv_cnt;

    t_rewrite_out pending_rewrites[$];
    int err_count;
    int send_idle_pct;
    int recv_stall_pct;

    split_path_tcp_dest_rewriter_unit #(.RULES(NRULES)) i_dut (.*);

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    function automatic logic [15:0] fold16(input logic [31:0] s);
        while (s > 32'hFFFF) s = (s & 32'hFFFF) + (s >> 16);
        return s[15:0];
    endfunction

    // Predict one beat and update the mirrored tables
    function automatic t_rewrite_out predict_rewrite(input t_beat b);
        t_rewrite_out r;
        logic [47:0] pkt;
        logic [47:0] target;
        logic        hit;
        logic [31:0] nd;
        logic [31:0] s;
        logic [31:0] ps;
        pkt = {b.dst_addr, b.dst_port};
        hit = 1'b0;
        target = '0;
        r = '0;
        case (b.action)
            ACT_SEND: begin
                for (int i = 0; i < snd_cnt; i++) begin
                    if (snd_pri[i] == pkt) begin
                        if (snd_pat[i][snd_pos[i]]) begin
                            hit = 1'b1;
                            target = snd_sec[i];
                        end
                        snd_pos[i] = snd_pos[i] + 6'd1;
                        break;
                    end
                end
            end
            ACT_RECV: begin
                for (int i = 0; i < rcv_cnt; i++) begin
                    if (rcv_sec[i] == pkt) begin
                        hit = 1'b1;
                        target = rcv_pri[i];
                        break;
                    end
                end
            end
            ACT_APPEND_SND: begin
                if (snd_cnt >= NRULES) r.status = 1'b1;
                else begin
                    snd_pri[snd_cnt] = {b.pri_addr, b.pri_port};
                    snd_sec[snd_cnt] = {b.sec_addr, b.sec_port};
                    snd_pat[snd_cnt] = b.pattern;
                    snd_pos[snd_cnt] = '0;
                    snd_cnt++;
                end
            end
            ACT_APPEND_RCV: begin
                if (rcv_cnt >= NRULES) r.status = 1'b1;
                else begin
                    rcv_pri[rcv_cnt] = {b.pri_addr, b.pri_port};
                    rcv_sec[rcv_cnt] = {b.sec_addr, b.sec_port};
                    rcv_cnt++;
                end
            end
            ACT_FLUSH_SND: snd_cnt = 0;
            ACT_FLUSH_RCV: rcv_cnt = 0;
            default: ;
        endcase
        if (hit) begin
            nd = target[47:16];
            // incremental update: ~HC + ~m + m'
            s = {16'd0, ~b.old_ck} + {16'd0, ~b.dst_addr[31:16]} + {16'd0, ~b.dst_addr[15:0]}
                + {16'd0, nd[31:16]} + {16'd0, nd[15:0]};
            ps = {16'd0, b.src_addr[31:16]} + {16'd0, b.src_addr[15:0]}
                + {16'd0, nd[31:16]} + {16'd0, nd[15:0]} + {16'd0, TCP_PROTO}
                + {16'd0, b.seg_len};
            r.rewritten = 1'b1;
            r.dst_addr = nd;
            r.dst_port = target[15:0];
            r.ip_ck = ~fold16(s);
            r.pseudo = fold16(ps);
        end else begin
            r.dst_addr = b.dst_addr;
            r.dst_port = b.dst_port;
            r.ip_ck = b.old_ck;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("tb: mismatch %s got %h want %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // Drive one beat and wait for it to be taken
    task automatic send_beat(input t_beat b);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid           <= 1'b1;
        i_action          <= b.action;
        i_pri_addr        <= b.pri_addr;
        i_pri_port        <= b.pri_port;
        i_sec_addr        <= b.sec_addr;
        i_sec_port        <= b.sec_port;
        i_pattern         <= b.pattern;
        i_src_addr        <= b.src_addr;
        i_dst_addr        <= b.dst_addr;
        i_dst_port        <= b.dst_port;
        i_segment_len     <= b.seg_len;
        i_old_ip_checksum <= b.old_ck;
        pending_rewrites.push_back(predict_rewrite(b));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic t_beat random_beat(input logic [2:0] act);
        t_beat b;
        logic [319:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom};
        b = raw[$bits(t_beat)-1:0];
        b.action = act;
        return b;
    endfunction

    // Packet aimed at a stored rule, or random
    function automatic t_beat packet_beat(input logic is_recv);
        t_beat b;
        int n;
        b = random_beat(is_recv ? ACT_RECV : ACT_SEND);
        n = is_recv ? rcv_cnt : snd_cnt;
        if (n > 0 && $urandom_range(9) < 8)
            {b.dst_addr, b.dst_port} = is_recv ? rcv_sec[$urandom_range(n - 1)]
                                               : snd_pri[$urandom_range(n - 1)];
        return b;
    endfunction

    // Receiver stall and result check
    always @(posedge i_clk) begin
        t_rewrite_out w;
        if (!i_rst_n) i_stall <= 1'b0;
        else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
            if (o_valid && !i_stall) begin
                if (pending_rewrites.size() == 0) begin
                    $display("tb: unexpected beat at %0t", $realtime);
                    err_count++;
                end else begin
                    w = pending_rewrites.pop_front();
                    if (o_rewritten !== w.rewritten)
                        report_mismatch("rewritten", o_rewritten, w.rewritten);
                    if (o_new_dst_addr !== w.dst_addr)
                        report_mismatch("dst_addr", o_new_dst_addr, w.dst_addr);
                    if (o_new_dst_port !== w.dst_port)
                        report_mismatch("dst_port", o_new_dst_port, w.dst_port);
                    if (o_new_ip_checksum !== w.ip_ck)
                        report_mismatch("ip_ck", o_new_ip_checksum, w.ip_ck);
                    if (o_pseudo_sum !== w.pseudo)
                        report_mismatch("pseudo", o_pseudo_sum, w.pseudo);
                    if (o_status !== w.status)
                        report_mismatch("status", o_status, w.status);
                end
            end
        end
    end

    // Directed: fill both tables past full, hit extremes, flush
    task automatic test_directed();
        t_beat b;
        b = '0;
        b.action = ACT_SEND; send_beat(b);
        b.action = ACT_RECV; send_beat(b);
        b.action = 3'd6; send_beat(b);
        b = '1; b.action = 3'd7; send_beat(b);
        b = '0; b.action = ACT_APPEND_SND; b.pattern = 64'h8000_0000_0000_0001;
        b.sec_addr = '1; b.sec_port = '1;
        send_beat(b);
        b = '1; b.action = ACT_APPEND_RCV; b.pri_addr = '0; b.pri_port = '0; send_beat(b);
        b = '0; b.action = ACT_SEND; send_beat(b);
        send_beat(b);
        b = '1; b.action = ACT_RECV; send_beat(b);
        for (int i = 0; i < NRULES; i++) send_beat(random_beat(ACT_APPEND_SND));
        send_beat(random_beat(ACT_APPEND_RCV));
        send_beat(random_beat(ACT_FLUSH_SND));
        send_beat(random_beat(ACT_FLUSH_RCV));
        for (int i = 0; i < NRULES + 1; i++) send_beat(random_beat(ACT_APPEND_RCV));
        send_beat(random_beat(ACT_FLUSH_RCV));
    endtask

    // Random: mostly packets on populated tables, occasional flushes
    task automatic test_random(input int n_beats);
        int pick;
        for (int k = 0; k < n_beats; k++) begin
            pick = $urandom_range(99);
            if (pick < 12) send_beat(random_beat(ACT_APPEND_SND));
            else if (pick < 24) send_beat(random_beat(ACT_APPEND_RCV));
            else if (pick < 26) send_beat(random_beat(ACT_FLUSH_SND));
            else if (pick < 28) send_beat(random_beat(ACT_FLUSH_RCV));
            else if (pick < 30) send_beat(random_beat(3'($urandom_range(7))));
            else if (pick < 68) send_beat(packet_beat(1'b0));
            else send_beat(packet_beat(1'b1));
        end
    endtask

    initial begin
        err_count = 0; send_idle_pct = 0; recv_stall_pct = 0;
        snd_cnt = 0; rcv_cnt = 0;
        for (int i = 0; i < NRULES; i++) snd_pos[i] = '0;
        i_rst_n = 1'b0; i_valid = 1'b0;
        {i_action, i_pri_addr, i_pri_port, i_sec_addr, i_sec_port, i_pattern, i_src_addr,
         i_dst_addr, i_dst_port, i_segment_len, i_old_ip_checksum} = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(120);
        send_idle_pct = 72; test_random(120);
        send_idle_pct = 0; recv_stall_pct = 72; test_random(120);
        send_idle_pct = 19; recv_stall_pct = 19; test_random(120);
        i_valid <= 1'b0;
        while (pending_rewrites.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (err_count == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

    initial begin
        #5ms;
        $display("tb: failure");
        $finish;
    end
endmodule
